FILE: rtl/assert_macros.svh
// assertion macros shared by the allocator modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication check
`define CHK_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("allocator check failed");

// next-cycle implication check
`define CHK_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

FILE: rtl/fpba_pkg.sv
// types and constants of the fit policy block allocator
package fpba_pkg;

    localparam int ADDR_W    = 20;
    localparam int SIZE_W    = 21;
    localparam int REQ_W     = 21;
    localparam int NEED_W    = 22;
    localparam int CNT_OUT_W = 7;
    localparam int CFG_W     = 21;
    localparam int CFG_IDX_W = 1;

    localparam logic [SIZE_W-1:0] ARENA_CAP   = SIZE_W'(1 << ADDR_W);
    localparam logic [SIZE_W-1:0] ARENA_RESET = SIZE_W'(65536);

    typedef enum logic [1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_COUNT = 2'd2,
        ACT_INIT  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FIT    = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_TOO_SMALL = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ARENA  = 1'b0,
        REG_POLICY = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        t_action              action;
        logic [REQ_W-1:0]     request_bytes;
        logic [ADDR_W-1:0]    payload_address;
    } t_req;

    typedef struct packed {
        t_status              status;
        logic [ADDR_W-1:0]    granted_offset;
        logic [SIZE_W-1:0]    granted_bytes;
        logic [CNT_OUT_W-1:0] small_free_count;
    } t_rsp;

    typedef struct packed {
        logic                 free;
        logic [SIZE_W-1:0]    size;
        logic [ADDR_W-1:0]    start;
    } t_entry;

    typedef struct packed {
        logic latch;
        logic scan_rd;
        logic shift_rd;
        logic rd_next;
        logic rd_prev;
        logic cap_next;
        logic cap_prev;
        logic init_wr;
        logic alloc_commit;
        logic ins_wr;
        logic merge_wr;
        logic count_sub;
        logic res_load;
    } t_cmd;

    typedef struct packed {
        t_action action;
        logic    found;
        logic    split;
        logic    init_ok;
        logic    shift_more;
        logic    dir_ins;
        logic    pend;
        logic    ptr_end;
    } t_sts;

endpackage

FILE: rtl/fpba_ram.sv
// generic single write port ram with registered read
module fpba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

FILE: rtl/fpba_ctrl.sv
// sequencing state machine of the allocator
`include "assert_macros.svh"
module fpba_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  fpba_pkg::t_action i_action,
    output logic             o_req_ready,
    output logic             o_rsp_valid,
    input  logic             i_rsp_ready,
    input  fpba_pkg::t_sts   i_sts,
    output fpba_pkg::t_cmd   o_cmd
);
    typedef enum logic [3:0] {
        S_BOOT, S_IDLE, S_SCAN, S_DECIDE, S_NB_NEXT, S_NB_PREV,
        S_NB_CAP, S_MERGE, S_SHIFT, S_INS, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_BOOT: begin
                o_cmd.init_wr = 1'b1;
                n_state       = S_IDLE;
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state = (i_action == fpba_pkg::ACT_INIT) ? S_DECIDE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (!i_sts.ptr_end) begin
                    o_cmd.scan_rd = 1'b1;
                end else if (!i_sts.pend) begin
                    n_state = (i_sts.action == fpba_pkg::ACT_COUNT) ? S_DONE : S_DECIDE;
                end
            end
            S_DECIDE: begin
                unique case (i_sts.action)
                    fpba_pkg::ACT_ALLOC: begin
                        if (i_sts.found) begin
                            o_cmd.alloc_commit = 1'b1;
                            n_state = i_sts.split ? S_SHIFT : S_DONE;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    fpba_pkg::ACT_FREE: begin
                        n_state = i_sts.found ? S_NB_NEXT : S_DONE;
                    end
                    fpba_pkg::ACT_INIT: begin
                        o_cmd.init_wr = i_sts.init_ok;
                        n_state       = S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_NB_NEXT: begin
                o_cmd.rd_next = 1'b1;
                n_state       = S_NB_PREV;
            end
            S_NB_PREV: begin
                o_cmd.cap_next = 1'b1;
                o_cmd.rd_prev  = 1'b1;
                n_state        = S_NB_CAP;
            end
            S_NB_CAP: begin
                o_cmd.cap_prev = 1'b1;
                n_state        = S_MERGE;
            end
            S_MERGE: begin
                o_cmd.merge_wr = 1'b1;
                n_state        = S_SHIFT;
            end
            S_SHIFT: begin
                if (i_sts.shift_more) begin
                    o_cmd.shift_rd = 1'b1;
                end else if (!i_sts.pend) begin
                    if (i_sts.dir_ins) begin
                        n_state = S_INS;
                    end else begin
                        o_cmd.count_sub = 1'b1;
                        n_state         = S_DONE;
                    end
                end
            end
            S_INS: begin
                o_cmd.ins_wr = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_rsp_ready) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_BOOT;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `CHK_IMP(a_valid_from_load, i_clk, i_rst_n, $rose(r_out_valid), $past(o_cmd.res_load))
    `CHK_NEXT(a_busy_after_accept, i_clk, i_rst_n, o_cmd.latch, r_state != S_IDLE)
    `CHK_IMP(a_ins_port_free, i_clk, i_rst_n, o_cmd.ins_wr, !i_sts.pend)
endmodule

FILE: rtl/fpba_datapath.sv
// block table, scan and shift datapath of the allocator
`include "assert_macros.svh"
module fpba_datapath #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [fpba_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [fpba_pkg::CFG_W-1:0]        i_cfg_data,
    input  fpba_pkg::t_req                    i_req,
    input  fpba_pkg::t_cmd                    i_cmd,
    output fpba_pkg::t_sts                    o_sts,
    output fpba_pkg::t_rsp                    o_rsp
);
    localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int ENT_W  = $bits(fpba_pkg::t_entry);
    localparam int NEED_W = fpba_pkg::NEED_W;
    localparam int SIZE_W = fpba_pkg::SIZE_W;
    localparam int ADDR_W = fpba_pkg::ADDR_W;
    localparam logic [NEED_W-1:0] HDR_N     = NEED_W'(HEADER_BYTES);
    localparam logic [NEED_W-1:0] MIN_SPLIT = NEED_W'(HEADER_BYTES + 4);
    localparam logic [SIZE_W-1:0] HDR_S     = SIZE_W'(HEADER_BYTES);
    localparam logic [ADDR_W-1:0] HDR_A     = ADDR_W'(HEADER_BYTES);
    localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_BLOCKS);

    // configuration
    logic [SIZE_W-1:0]      r_arena;
    logic                   r_policy;
    // request context
    fpba_pkg::t_action      r_act;
    logic [fpba_pkg::REQ_W-1:0] r_req;
    logic [ADDR_W-1:0]      r_addr;
    logic [NEED_W-1:0]      r_need;
    // table bookkeeping
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       r_ptr;
    logic                   r_found;
    logic [IDX_W-1:0]       r_pick;
    fpba_pkg::t_entry       r_pick_ent;
    fpba_pkg::t_entry       r_nxt;
    fpba_pkg::t_entry       r_prv;
    logic [CNT_W-1:0]       r_small;
    logic                   r_pend_scan;
    logic                   r_pend_shift;
    logic [IDX_W-1:0]       r_rd_idx;
    logic                   r_dir_ins;
    logic                   r_split;
    logic [1:0]             r_k;
    fpba_pkg::t_rsp         r_rsp;

    logic                   w_we, w_re;
    logic [IDX_W-1:0]       w_waddr, w_raddr;
    logic [ENT_W-1:0]       w_wdata, w_rdata;
    fpba_pkg::t_entry       rd_ent;

    logic [NEED_W-1:0]      rem;
    logic                   split;
    logic [ADDR_W-1:0]      new_start;
    logic [SIZE_W-1:0]      new_size;
    logic [ADDR_W-1:0]      goff;
    logic                   fits, better, match, is_small;
    logic                   has_nxt, has_prv, nf, pf;
    logic [SIZE_W-1:0]      size_c;
    fpba_pkg::t_entry       merged;
    logic [IDX_W-1:0]       w_idx;
    logic [1:0]             k;
    logic [SIZE_W-1:0]      total;
    logic                   init_ok;
    logic                   shift_more;
    fpba_pkg::t_rsp         rsp_c;
    logic [NEED_W-1:0]      need_in;

    fpba_ram #(.WIDTH(ENT_W), .DEPTH(MAX_BLOCKS)) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign rd_ent = fpba_pkg::t_entry'(w_rdata);

    // allocation split arithmetic
    assign rem       = NEED_W'(r_pick_ent.size) - r_need;
    assign split     = (rem >= MIN_SPLIT) && (r_count < CNT_MAX);
    assign new_start = ADDR_W'(NEED_W'(r_pick_ent.start) + HDR_N + r_need);
    assign new_size  = SIZE_W'(rem - HDR_N);
    assign goff      = r_pick_ent.start + HDR_A;

    // per-entry scan tests
    assign fits     = rd_ent.free && (NEED_W'(rd_ent.size) >= r_need);
    assign better   = !r_found || (r_policy ? (rd_ent.size > r_pick_ent.size)
                                            : (rd_ent.size < r_pick_ent.size));
    assign match    = ((rd_ent.start + HDR_A) == r_addr);
    assign is_small = rd_ent.free && (rd_ent.size < SIZE_W'(r_req));

    // coalescing on free
    assign has_nxt = ((CNT_W'(r_pick) + CNT_W'(1)) < r_count);
    assign has_prv = (r_pick != '0);
    assign nf      = has_nxt && r_nxt.free;
    assign pf      = has_prv && r_prv.free;
    assign size_c  = nf ? (r_pick_ent.size + r_nxt.size + HDR_S) : r_pick_ent.size;
    assign w_idx   = pf ? (r_pick - IDX_W'(1)) : r_pick;
    assign k       = {1'b0, nf} + {1'b0, pf};
    always_comb begin
        merged.free = 1'b1;
        if (pf) begin
            merged.size  = r_prv.size + size_c + HDR_S;
            merged.start = r_prv.start;
        end else begin
            merged.size  = size_c;
            merged.start = r_pick_ent.start;
        end
    end

    // arena format
    assign total   = (r_arena > fpba_pkg::ARENA_CAP) ? fpba_pkg::ARENA_CAP : r_arena;
    assign init_ok = (total >= SIZE_W'(HEADER_BYTES + 4));

    assign shift_more = r_dir_ins ? (r_ptr > CNT_W'(r_pick)) : (r_ptr < r_count);
    assign need_in = (NEED_W'(i_req.request_bytes) + NEED_W'(3)) & ~NEED_W'(3);

    // read port
    assign w_re = i_cmd.scan_rd | i_cmd.shift_rd | i_cmd.rd_next | i_cmd.rd_prev;
    always_comb begin
        if (i_cmd.rd_next) begin
            w_raddr = r_pick + IDX_W'(1);
        end else if (i_cmd.rd_prev) begin
            w_raddr = r_pick - IDX_W'(1);
        end else begin
            w_raddr = r_ptr[IDX_W-1:0];
        end
    end

    // write port, shift copies have the port to themselves
    always_comb begin
        w_we    = 1'b1;
        w_waddr = '0;
        w_wdata = '0;
        if (r_pend_shift) begin
            w_waddr = r_dir_ins ? (r_rd_idx + IDX_W'(1)) : (r_rd_idx - IDX_W'(r_k));
            w_wdata = w_rdata;
        end else if (i_cmd.init_wr) begin
            w_wdata = {1'b1, total - HDR_S, ADDR_W'(0)};
        end else if (i_cmd.alloc_commit) begin
            w_waddr = r_pick;
            w_wdata = {1'b0, split ? SIZE_W'(r_need) : r_pick_ent.size, r_pick_ent.start};
        end else if (i_cmd.ins_wr) begin
            w_waddr = r_pick + IDX_W'(1);
            w_wdata = {1'b1, new_size, new_start};
        end else if (i_cmd.merge_wr) begin
            w_waddr = w_idx;
            w_wdata = merged;
        end else begin
            w_we = 1'b0;
        end
    end

    always_comb begin
        rsp_c = '0;
        case (r_act)
            fpba_pkg::ACT_ALLOC: begin
                if (r_found) begin
                    rsp_c.status         = fpba_pkg::ST_OK;
                    rsp_c.granted_offset = goff;
                    rsp_c.granted_bytes  = r_split ? SIZE_W'(r_need) : r_pick_ent.size;
                end else begin
                    rsp_c.status = fpba_pkg::ST_NO_FIT;
                end
            end
            fpba_pkg::ACT_FREE: begin
                rsp_c.status = r_found ? fpba_pkg::ST_OK : fpba_pkg::ST_NOT_FOUND;
            end
            fpba_pkg::ACT_COUNT: begin
                rsp_c.status           = fpba_pkg::ST_OK;
                rsp_c.small_free_count = fpba_pkg::CNT_OUT_W'(r_small);
            end
            fpba_pkg::ACT_INIT: begin
                rsp_c.status = init_ok ? fpba_pkg::ST_OK : fpba_pkg::ST_TOO_SMALL;
            end
            default: begin
                rsp_c = '0;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arena      <= fpba_pkg::ARENA_RESET;
            r_policy     <= 1'b0;
            r_count      <= CNT_W'(1);
            r_found      <= 1'b0;
            r_pend_scan  <= 1'b0;
            r_pend_shift <= 1'b0;
            r_dir_ins    <= 1'b0;
            r_split      <= 1'b0;
            r_k          <= '0;
            r_ptr        <= '0;
            r_small      <= '0;
            r_act        <= fpba_pkg::ACT_ALLOC;
        end else begin
            r_pend_scan  <= i_cmd.scan_rd;
            r_pend_shift <= i_cmd.shift_rd;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    fpba_pkg::REG_ARENA:  r_arena  <= i_cfg_data;
                    fpba_pkg::REG_POLICY: r_policy <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.latch) begin
                r_act   <= i_req.action;
                r_ptr   <= '0;
                r_found <= 1'b0;
                r_small <= '0;
            end
            if (r_pend_scan) begin
                case (r_act)
                    fpba_pkg::ACT_ALLOC: begin
                        if (fits && better) r_found <= 1'b1;
                    end
                    fpba_pkg::ACT_FREE: begin
                        if (match) r_found <= 1'b1;
                    end
                    fpba_pkg::ACT_COUNT: begin
                        if (is_small) r_small <= r_small + CNT_W'(1);
                    end
                    default: ;
                endcase
            end
            if (i_cmd.scan_rd) begin
                r_ptr <= r_ptr + CNT_W'(1);
            end
            if (i_cmd.shift_rd) begin
                r_ptr <= r_dir_ins ? (r_ptr - CNT_W'(1)) : (r_ptr + CNT_W'(1));
            end
            if (i_cmd.alloc_commit) begin
                r_split   <= split;
                r_dir_ins <= 1'b1;
                r_ptr     <= r_count - CNT_W'(1);
            end
            if (i_cmd.merge_wr) begin
                r_dir_ins <= 1'b0;
                r_k       <= k;
                r_ptr     <= CNT_W'(w_idx) + CNT_W'(1) + CNT_W'(k);
            end
            if (i_cmd.init_wr) begin
                r_count <= CNT_W'(1);
            end else if (i_cmd.ins_wr) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.count_sub) begin
                r_count <= r_count - CNT_W'(r_k);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rd_idx <= w_raddr;
        if (i_cmd.latch) begin
            r_req  <= i_req.request_bytes;
            r_addr <= i_req.payload_address;
            r_need <= need_in;
        end
        if (r_pend_scan) begin
            if ((r_act == fpba_pkg::ACT_ALLOC && fits && better) ||
                (r_act == fpba_pkg::ACT_FREE && match && !r_found)) begin
                r_pick     <= r_rd_idx;
                r_pick_ent <= rd_ent;
            end
        end
        if (i_cmd.cap_next) r_nxt <= rd_ent;
        if (i_cmd.cap_prev) r_prv <= rd_ent;
        if (i_cmd.res_load) r_rsp <= rsp_c;
    end

    assign o_rsp = r_rsp;

    always_comb begin
        o_sts.action     = r_act;
        o_sts.found      = r_found;
        o_sts.split      = split;
        o_sts.init_ok    = init_ok;
        o_sts.shift_more = shift_more;
        o_sts.dir_ins    = r_dir_ins;
        o_sts.pend       = r_pend_scan | r_pend_shift;
        o_sts.ptr_end    = (r_ptr == r_count);
    end

    `CHK_IMP(a_count_range, i_clk, i_rst_n, 1'b1, (r_count != '0) && (r_count <= CNT_MAX))
    `CHK_IMP(a_one_writer, i_clk, i_rst_n, r_pend_shift, !(i_cmd.init_wr || i_cmd.alloc_commit || i_cmd.ins_wr || i_cmd.merge_wr))
    `CHK_IMP(a_split_room, i_clk, i_rst_n, i_cmd.ins_wr, r_count < CNT_MAX)
endmodule

FILE: rtl/fit_policy_block_allocator_top.sv
// top level of the fit policy block allocator
//
//  channel   direction  handshake                     payload
//  request   in         i_req_valid / o_req_ready     i_req  (action, bytes, address)
//  response  out        o_rsp_valid / i_rsp_ready     o_rsp  (status, offset, bytes, count)
//  config    in         i_cfg_we (no wait)            i_cfg_idx, i_cfg_data
//
// one request at a time; the block table sits in a single ram with a registered read
// allocate, free and count scan all n live entries, one read a cycle;
// a split adds a shift pass and the insert; a free adds neighbour reads,
// the merge and a shift pass
// after reset the arena is formatted before the first request is taken
// the response sits in its own register; a new request is taken while it waits
module fit_policy_block_allocator_top #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_req_valid,
    output logic                            o_req_ready,
    input  fpba_pkg::t_req                  i_req,
    output logic                            o_rsp_valid,
    input  logic                            i_rsp_ready,
    output fpba_pkg::t_rsp                  o_rsp,
    input  logic                            i_cfg_we,
    input  logic [fpba_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fpba_pkg::CFG_W-1:0]      i_cfg_data
);
    // command and status between sequencer and datapath
    fpba_pkg::t_cmd cmd;
    fpba_pkg::t_sts sts;

    // sequencer: scan, neighbour reads, merge or split, shift pass, response
    fpba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_action    (i_req.action),
        .o_req_ready (o_req_ready),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // datapath: block table ram, fit search, coalescing arithmetic, output register
    fpba_datapath #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (i_req),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_rsp      (o_rsp)
    );
endmodule
